/* rtl/core/fdrs_pkg.sv */
// Shared types and constants for the fill/drain/rinse sequencer.
// No dependencies; imported by every module of the block.
package fdrs_pkg;

  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned LimitW    = 22;  // 4095 s * 1000 fits
  localparam int unsigned CountW    = 8;
  localparam int unsigned RelayW    = 4;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned StatusW   = 2;

  localparam int unsigned MsPerS    = 1000;

  localparam logic [CfgIdxW-1:0] RegFillTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDrainTime   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDebounce    = 2'd2;

  localparam logic [LimitW-1:0]  FillLimitRst   = 22'd60000;
  localparam logic [LimitW-1:0]  DrainLimitRst  = 22'd10000;
  localparam logic [CountW-1:0]  DebounceRst    = 8'd5;

  localparam logic [RelayW-1:0] RelayCleanIn   = 4'b0001;
  localparam logic [RelayW-1:0] RelayCleanOut  = 4'b0010;
  localparam logic [RelayW-1:0] RelaySampleIn  = 4'b0100;
  localparam logic [RelayW-1:0] RelaySampleOut = 4'b1000;

  localparam logic [StatusW-1:0] StatBusy  = 2'd0;
  localparam logic [StatusW-1:0] StatReady = 2'd1;
  localparam logic [StatusW-1:0] StatError = 2'd2;

  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_PREPARE  = 2'd1,
    OP_FINISHED = 2'd2,
    OP_RESET    = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_CLEAN_FILL   = 7'b0000010,
    PH_CLEAN_DRAIN  = 7'b0000100,
    PH_SAMPLE_FILL  = 7'b0001000,
    PH_WAIT_READ    = 7'b0010000,
    PH_SAMPLE_DRAIN = 7'b0100000,
    PH_FINAL_FILL   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [LimitW-1:0] fill_limit_ms;
    logic [LimitW-1:0] drain_limit_ms;
    logic [CountW-1:0] debounce_count;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] poll_status;
    logic [RelayW-1:0]  relay_drive;
    logic [PhaseW-1:0]  phase;
  } res_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_IDLE:         code = 3'd0;
      PH_CLEAN_FILL:   code = 3'd1;
      PH_CLEAN_DRAIN:  code = 3'd2;
      PH_SAMPLE_FILL:  code = 3'd3;
      PH_WAIT_READ:    code = 3'd4;
      PH_SAMPLE_DRAIN: code = 3'd5;
      PH_FINAL_FILL:   code = 3'd6;
      default:         code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/fill_drain_rinse_sequencer_unit.sv */
// Fill/drain/rinse sequencer for a sensor chamber, top level.
// Depends on fdrs_pkg, fdrs_cfg_regs and fdrs_core.
//
// Each accepted request is one command (poll, prepare, finished, reset) and
// yields exactly one result: poll status, relay drive and sequence phase.
// A request is registered on entry, evaluated against the sequencer state once
// the output register can take it, and lands in that register; the state
// updates at that same edge. With no stall the block takes one request per
// cycle; each result passes the input register, then the output register.
// Throughput is set by the single state update per request. Configuration writes
// are always ready; timeouts are scaled to milliseconds as they are written.
module fill_drain_rinse_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fdrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fdrs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic                          switch_raw_i,
  input  logic [fdrs_pkg::TimeW-1:0]    now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fdrs_pkg::StatusW-1:0]  poll_status_o,
  output logic [fdrs_pkg::RelayW-1:0]   relay_drive_o,
  output logic [fdrs_pkg::PhaseW-1:0]   phase_o
);
  import fdrs_pkg::*;

  cfg_t             cfg;
  res_t             res;
  res_t             res_q;
  logic             out_valid_q;
  logic             in_valid_q;
  op_e              op_q;
  logic             sw_q;
  logic [TimeW-1:0] now_q;
  logic             out_free;
  logic             step;
  logic             in_take;

  assign cfg_ready_o = 1'b1;

  fdrs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Output slot frees when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_e'(opcode_i);
      sw_q  <= switch_raw_i;
      now_q <= now_ms_i;
    end
  end

  fdrs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .opcode_i     (op_q),
    .switch_raw_i (sw_q),
    .now_ms_i     (now_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign poll_status_o = res_q.poll_status;
  assign relay_drive_o = res_q.relay_drive;
  assign phase_o       = res_q.phase;

endmodule

/* rtl/core/fdrs_cfg_regs.sv */
// Configuration registers of the sequencer; timeouts are kept in milliseconds.
// Depends on fdrs_pkg.
module fdrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [fdrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fdrs_pkg::CfgDataW-1:0] cfg_data_i,
  output fdrs_pkg::cfg_t                cfg_o
);
  import fdrs_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [LimitW-1:0] limit_ms;

  // Scale seconds to milliseconds once, at write time.
  assign limit_ms = LimitW'(cfg_data_i) * LimitW'(MsPerS);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFillTimeout: cfg_d.fill_limit_ms  = limit_ms;
        RegDrainTime:   cfg_d.drain_limit_ms = limit_ms;
        RegDebounce:    cfg_d.debounce_count = cfg_data_i[CountW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fill_limit_ms: FillLimitRst, drain_limit_ms: DrainLimitRst,
                 debounce_count: DebounceRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/fdrs_core.sv */
// Sequencer state and next-state logic: phase machine, debouncer, fill/drain timer.
// Depends on fdrs_pkg.
module fdrs_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  fdrs_pkg::op_e                opcode_i,
  input  logic                         switch_raw_i,
  input  logic [fdrs_pkg::TimeW-1:0]   now_ms_i,
  input  fdrs_pkg::cfg_t               cfg_i,
  output fdrs_pkg::res_t               res_o
);
  import fdrs_pkg::*;

  phase_e            phase_q, phase_d;
  logic              prepare_q, prepare_d;
  logic              cleaning_q, cleaning_d;
  logic              timing_q, timing_d;
  logic              error_q, error_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [CountW-1:0] high_q, high_d;
  logic [CountW-1:0] low_q, low_d;
  logic              level_q, level_d;
  logic [RelayW-1:0] relay_q, relay_d;

  logic [CountW-1:0] high_inc, low_inc, sat_count;
  logic              deb_level;
  logic [CountW-1:0] deb_high, deb_low;
  logic [TimeW-1:0]  elapsed;
  logic              fill_over, drain_over;
  logic              is_fill, is_drain;
  logic [RelayW-1:0] mask;
  logic              advance;
  logic [StatusW-1:0] status;

  // Debouncer next values for the current sample.
  assign high_inc  = high_q + 1'b1;
  assign low_inc   = low_q + 1'b1;
  assign sat_count = cfg_i.debounce_count + 1'b1;

  always_comb begin
    deb_level = level_q;
    deb_high  = high_q;
    deb_low   = low_q;
    if (switch_raw_i) begin
      deb_low  = '0;
      deb_high = high_inc;
      if (high_inc >= cfg_i.debounce_count) begin
        deb_high  = sat_count;
        deb_level = 1'b1;
      end
    end else begin
      deb_high = '0;
      deb_low  = low_inc;
      if (low_inc >= cfg_i.debounce_count) begin
        deb_low   = sat_count;
        deb_level = 1'b0;
      end
    end
  end

  assign elapsed    = now_ms_i - start_q;
  assign fill_over  = elapsed > TimeW'(cfg_i.fill_limit_ms);
  assign drain_over = elapsed > TimeW'(cfg_i.drain_limit_ms);

  always_comb begin
    is_fill  = 1'b0;
    is_drain = 1'b0;
    mask     = '0;
    case (phase_q)
      PH_CLEAN_FILL: begin
        is_fill = 1'b1;
        mask    = RelayCleanIn;
      end
      PH_CLEAN_DRAIN: begin
        is_drain = 1'b1;
        mask     = RelayCleanOut;
      end
      PH_SAMPLE_FILL: begin
        is_fill = 1'b1;
        mask    = RelaySampleIn;
      end
      PH_SAMPLE_DRAIN: begin
        is_drain = 1'b1;
        mask     = RelaySampleOut;
      end
      PH_FINAL_FILL: begin
        is_fill = 1'b1;
        mask    = RelayCleanIn;
      end
      default: begin
        is_fill = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    prepare_d  = prepare_q;
    cleaning_d = cleaning_q;
    timing_d   = timing_q;
    error_d    = error_q;
    start_d    = start_q;
    high_d     = high_q;
    low_d      = low_q;
    level_d    = level_q;
    relay_d    = relay_q;
    status     = StatBusy;
    advance    = 1'b0;

    case (opcode_i)
      OP_POLL: begin
        if (error_q) begin
          status = StatError;
        end else if (phase_q == PH_WAIT_READ && !cleaning_q) begin
          prepare_d = 1'b0;
          status    = StatReady;
        end else if (prepare_q || cleaning_q) begin
          advance = 1'b1;
        end
      end
      OP_PREPARE: begin
        prepare_d  = 1'b1;
        cleaning_d = 1'b0;
        phase_d    = PH_CLEAN_FILL;
      end
      OP_FINISHED: begin
        cleaning_d = 1'b1;
      end
      default: begin
        relay_d    = '0;
        prepare_d  = 1'b0;
        cleaning_d = 1'b0;
        timing_d   = 1'b0;
        error_d    = 1'b0;
        phase_d    = PH_IDLE;
      end
    endcase

    if (advance && phase_q == PH_WAIT_READ && cleaning_q) begin
      phase_d = PH_SAMPLE_DRAIN;
    end

    if (advance && (is_fill || is_drain)) begin
      high_d  = deb_high;
      low_d   = deb_low;
      level_d = deb_level;
      if (is_fill) begin
        if (deb_level) begin
          relay_d  = relay_q & ~mask;
          timing_d = 1'b0;
          case (phase_q)
            PH_CLEAN_FILL:  phase_d = PH_CLEAN_DRAIN;
            PH_SAMPLE_FILL: phase_d = PH_WAIT_READ;
            PH_FINAL_FILL: begin
              phase_d    = PH_IDLE;
              cleaning_d = 1'b0;
            end
            default:        phase_d = phase_q;
          endcase
        end else if (!timing_q) begin
          start_d  = now_ms_i;
          timing_d = 1'b1;
          relay_d  = relay_q | mask;
        end else if (fill_over) begin
          error_d  = 1'b1;
          timing_d = 1'b0;
          relay_d  = relay_q & ~mask;
        end
      end else begin
        if (deb_level) begin
          relay_d = relay_q | mask;
        end else if (!timing_q) begin
          start_d  = now_ms_i;
          timing_d = 1'b1;
          relay_d  = relay_q | mask;
        end else if (drain_over) begin
          timing_d = 1'b0;
          relay_d  = relay_q & ~mask;
          phase_d  = (phase_q == PH_CLEAN_DRAIN) ? PH_SAMPLE_FILL : PH_FINAL_FILL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      prepare_q  <= 1'b0;
      cleaning_q <= 1'b0;
      timing_q   <= 1'b0;
      error_q    <= 1'b0;
      start_q    <= '0;
      high_q     <= '0;
      low_q      <= '0;
      level_q    <= 1'b0;
      relay_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      prepare_q  <= prepare_d;
      cleaning_q <= cleaning_d;
      timing_q   <= timing_d;
      error_q    <= error_d;
      start_q    <= start_d;
      high_q     <= high_d;
      low_q      <= low_d;
      level_q    <= level_d;
      relay_q    <= relay_d;
    end
  end

  assign res_o = '{poll_status: status, relay_drive: relay_d, phase: phase_code(phase_d)};

endmodule
